[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [7:0]  ATTR         = 8'h0F;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_NUL       = 8'h00;
  localparam logic [15:0] BLANK_CELL   = {ATTR, CH_SPACE};

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

[hdl/text_console_writer_unit.sv]
// Text console writer: screen store, cursor and scroll sequencer.
//
//  channel | ports                        | direction
//  --------+------------------------------+----------
//  in      | in_valid, in_stall, in_data  | request
//  out     | out_valid, out_stall, out_data | result
//
// Put, read and unused opcode: accept, execute, then load the result register;
// an in-range read also passes through S_READ for the registered memory read.
// Clear: blanks every cell, one store write per cycle.
// Scroll: one cell copied up a row per cycle, then bottom row blanked.
// After reset a clearing pass over all ROWS*COLS cells runs with in_stall high.
// A finished result waits in the output register; a new transaction is taken meanwhile.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CELL_COUNT = COLS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLS);
  localparam int RW         = $clog2(ROWS);
  localparam int IXW        = (AW + 1 > 11) ? AW + 1 : 11;

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0] mem_wdata;

  state_t state_r, state_nxt;
  in_t    item_r, item_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [15:0] value_r, value_nxt;
  logic        scr_r, scr_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic is_nul, is_nl, is_bs, is_prn;
  logic col_last, row_last, col_zero;
  logic scroll_hit, in_range, out_free, sweep_last, move_issue;
  logic [IXW-1:0] idx_ext;

  always_comb begin
    is_nul     = (item_r.char_code == CH_NUL);
    is_nl      = (item_r.char_code == CH_NEWLINE);
    is_bs      = (item_r.char_code == CH_BACKSPACE);
    is_prn     = !is_nul && !is_nl && !is_bs;
    col_last   = (col_r == CW'(COLS - 1));
    row_last   = (row_r == RW'(ROWS - 1));
    col_zero   = (col_r == '0);
    scroll_hit = row_last && (is_nl || (is_prn && col_last));
    idx_ext    = IXW'(item_r.cell_index);
    in_range   = (idx_ext < IXW'(CELL_COUNT));
    out_free   = !out_valid_r || !out_stall;
    sweep_last = (cnt_r == AW'(CELL_COUNT - 1));
    move_issue = (cnt_r < AW'(MOVE_COUNT));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (sweep_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (item_r.opcode)
          OP_PUT:   state_nxt = scroll_hit ? S_SCROLL : S_DONE;
          OP_READ:  state_nxt = in_range ? S_READ : S_DONE;
          OP_CLEAR: state_nxt = S_CLEAR;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_READ:   state_nxt = S_DONE;
      S_SCROLL: if (cnt_r == AW'(MOVE_COUNT)) state_nxt = S_BLANK;
      S_BLANK:  if (sweep_last) state_nxt = S_DONE;
      S_CLEAR:  if (sweep_last) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = BLANK_CELL;
    mem_raddr = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_INIT, S_BLANK, S_CLEAR: mem_we = 1'b1;
      S_EXEC: begin
        if (item_r.opcode == OP_PUT) begin
          if (is_bs && !col_zero) begin
            mem_we    = 1'b1;
            mem_waddr = addr_r - 1'b1;
          end else if (is_prn) begin
            mem_we    = 1'b1;
            mem_waddr = addr_r;
            mem_wdata = {ATTR, item_r.char_code};
          end
        end else if (item_r.opcode == OP_READ) begin
          mem_raddr = AW'(item_r.cell_index);
        end
      end
      S_SCROLL: begin
        if (move_issue) mem_raddr = cnt_r + AW'(COLS);
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wa_r;
          mem_wdata = rdata_r;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    value_nxt     = value_r;
    scr_nxt       = scr_r;
    pend_nxt      = 1'b0;
    wa_nxt        = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_INIT, S_BLANK, S_CLEAR: cnt_nxt = sweep_last ? '0 : cnt_r + 1'b1;
      S_IDLE: if (in_valid) item_nxt = in_data;
      S_EXEC: begin
        value_nxt = '0;
        scr_nxt   = 1'b0;
        cnt_nxt   = '0;
        case (item_r.opcode)
          OP_PUT: begin
            if (scroll_hit) begin
              scr_nxt  = 1'b1;
              col_nxt  = '0;
              addr_nxt = AW'(MOVE_COUNT);
            end else if (is_nl) begin
              col_nxt  = '0;
              row_nxt  = row_r + 1'b1;
              addr_nxt = addr_r - AW'(col_r) + AW'(COLS);
            end else if (is_bs) begin
              if (!col_zero) begin
                col_nxt  = col_r - 1'b1;
                addr_nxt = addr_r - 1'b1;
              end
            end else if (is_prn) begin
              addr_nxt = addr_r + 1'b1;
              if (col_last) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            col_nxt  = '0;
            row_nxt  = '0;
            addr_nxt = '0;
          end
          default: ;
        endcase
      end
      S_READ: value_nxt = rdata_r;
      S_SCROLL: begin
        pend_nxt = move_issue;
        if (move_issue) cnt_nxt = cnt_r + 1'b1;
        else            cnt_nxt = AW'(MOVE_COUNT);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_value = value_r;
          out_data_nxt.cursor_col = 7'(col_r);
          out_data_nxt.cursor_row = 5'(row_r);
          out_data_nxt.scrolled   = scr_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      addr_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    value_r    <= value_nxt;
    scr_r      <= scr_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/tcw_checker.sv]
// Port-level checker for the text console writer, bound to the top level.
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled transaction dropped or changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      out_data.cursor_col == 7'd0 && out_data.cursor_row == 5'(ROWS - 1))
    else $error("scroll left cursor off the last row start");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("activity straight after reset");

endmodule

bind text_console_writer_unit tcw_checker #(
  .ROWS(ROWS)
) u_tcw_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
